>>> design/pulse_channel_with_sweep_top_defines.svh
// assertion macros for the pulse channel block
// needs signals named clock and reset in the module that uses them
`ifndef PULSE_CHANNEL_WITH_SWEEP_TOP_DEFINES_SVH
`define PULSE_CHANNEL_WITH_SWEEP_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcs assertion failed");

// next-cycle implication, checked outside reset
`define PCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcs assertion failed");

`endif

>>> design/pcs_pkg.sv
// shared codes, constants, types and helper functions for the pulse channel
// no dependencies
package pcs_pkg;

   // command codes
   localparam logic [2:0] CMD_WRITE    = 3'd0;
   localparam logic [2:0] CMD_READ     = 3'd1;
   localparam logic [2:0] CMD_PERIOD   = 3'd2;
   localparam logic [2:0] CMD_LENGTH   = 3'd3;
   localparam logic [2:0] CMD_ENVELOPE = 3'd4;
   localparam logic [2:0] CMD_SWEEP    = 3'd5;

   // register numbers after folding
   localparam logic [2:0] REG_SWEEP     = 3'd0;
   localparam logic [2:0] REG_DUTY_LEN  = 3'd1;
   localparam logic [2:0] REG_ENVELOPE  = 3'd2;
   localparam logic [2:0] REG_FREQ_LOW  = 3'd3;
   localparam logic [2:0] REG_FREQ_HIGH = 3'd4;

   localparam logic [7:0]  FREQ_HIGH_READ_MASK = 8'hC7;
   localparam logic [11:0] FREQ_SPAN           = 12'd2048;
   localparam logic [6:0]  LENGTH_FULL         = 7'd64;

   // duty patterns, bit n is step n of the 8-step sequence
   localparam logic [7:0] DUTY_WAVE [4] = '{8'b1000_0000, 8'b1000_0001,
                                           8'b1110_0001, 8'b0111_1110};

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] level;
      logic       running;
   } rsp_type;

   // register index folded modulo five
   function automatic logic [2:0] reg_fold(input logic [3:0] idx);
      logic [2:0] r;
      case (idx)
         4'd0, 4'd5, 4'd10, 4'd15: r = REG_SWEEP;
         4'd1, 4'd6, 4'd11:        r = REG_DUTY_LEN;
         4'd2, 4'd7, 4'd12:        r = REG_ENVELOPE;
         4'd3, 4'd8, 4'd13:        r = REG_FREQ_LOW;
         default:                  r = REG_FREQ_HIGH;
      endcase
      return r;
   endfunction

   // period timer reload, (2048 - freq) * 4
   function automatic logic [13:0] timer_reload(input logic [10:0] freq);
      logic [11:0] span;
      span = FREQ_SPAN - {1'b0, freq};
      return {span, 2'b00};
   endfunction

   // next sweep frequency, bit 11 flags overflow past 2047
   function automatic logic [11:0] sweep_target(input logic [10:0] shadow,
                                                input logic [2:0]  shift,
                                                input logic        sub);
      logic [11:0] delta;
      delta = {1'b0, shadow >> shift};
      return sub ? ({1'b0, shadow} - delta) : ({1'b0, shadow} + delta);
   endfunction

endpackage

>>> design/pcs_req_if.sv
// request channel for the pulse channel: valid, ready and the request fields
// no dependencies
interface pcs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [3:0] reg_index;
   logic [7:0] write_data;

   modport source (output valid, output command, output reg_index, output write_data,
                   input ready);
   modport sink (input valid, input command, input reg_index, input write_data,
                 output ready);
endinterface

>>> design/pcs_rsp_if.sv
// result channel for the pulse channel: valid, ready and the result fields
// no dependencies
interface pcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [3:0] level;
   logic       running;

   modport source (output valid, output read_data, output level, output running,
                   input ready);
   modport sink (input valid, input read_data, input level, input running,
                 output ready);
endinterface

>>> design/pulse_channel_with_sweep_top.sv
// pulse channel with frequency sweep, top level
// uses pcs_pkg, pcs_req_if, pcs_rsp_if and pulse_channel_with_sweep_top_defines.svh
//
//  channel    | direction | fields
//  -----------+-----------+-------------------------------------
//  req_chan   | in        | command, reg_index, write_data
//  rsp_chan   | out       | read_data, level, running
//
// one request per cycle while ready is high: all channel state updates at the edge
// that takes the request, which also writes the result into a two-entry output queue
// req ready drops only while both queue entries hold results not yet taken
// synchronous active-high reset clears all channel state and empties the queue
`include "pulse_channel_with_sweep_top_defines.svh"

module pulse_channel_with_sweep_top (
   input logic       clock,
   input logic       reset,
   pcs_req_if.sink   req_chan,
   pcs_rsp_if.source rsp_chan
);

   // channel state
   logic [6:0]  sweep_reg_ff, sweep_reg_in;
   logic [7:0]  duty_length_reg_ff, duty_length_reg_in;
   logic [7:0]  envelope_reg_ff, envelope_reg_in;
   logic [7:0]  freq_low_reg_ff, freq_low_reg_in;
   logic [7:0]  freq_high_reg_ff, freq_high_reg_in;
   logic [10:0] freq_loaded_ff, freq_loaded_in;
   logic [13:0] period_timer_ff, period_timer_in;
   logic [2:0]  duty_position_ff, duty_position_in;
   logic [6:0]  length_left_ff, length_left_in;
   logic [3:0]  volume_now_ff, volume_now_in;
   logic [3:0]  envelope_timer_ff, envelope_timer_in;
   logic        envelope_active_ff, envelope_active_in;
   logic        dac_on_ff, dac_on_in;
   logic        channel_on_ff, channel_on_in;
   logic [3:0]  sweep_timer_ff, sweep_timer_in;
   logic        sweep_active_ff, sweep_active_in;
   logic [10:0] shadow_freq_ff, shadow_freq_in;
   logic [3:0]  level_out_ff, level_out_in;

   // output queue
   pcs_pkg::rsp_type queue_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;

   logic             req_accept;
   logic             rsp_take;
   logic [2:0]       reg_sel;
   logic [2:0]       sw_shift;
   logic [2:0]       sw_period;
   logic [2:0]       env_period;
   logic [10:0]      trig_freq;
   logic [11:0]      trig_check;
   logic [11:0]      sw_first;
   logic [11:0]      sw_second;
   logic [7:0]       rd_data;
   pcs_pkg::rsp_type rsp_next;

   // handshakes
   assign req_chan.ready = (count_ff != 2'd2);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;

   // decoded fields and sweep arithmetic
   assign reg_sel    = pcs_pkg::reg_fold(req_chan.reg_index);
   assign sw_shift   = sweep_reg_ff[2:0];
   assign sw_period  = sweep_reg_ff[6:4];
   assign env_period = envelope_reg_ff[2:0];
   assign trig_freq  = {req_chan.write_data[2:0], freq_loaded_ff[7:0]};
   assign trig_check = pcs_pkg::sweep_target(trig_freq, sw_shift, sweep_reg_ff[3]);
   assign sw_first   = pcs_pkg::sweep_target(shadow_freq_ff, sw_shift, sweep_reg_ff[3]);
   assign sw_second  = pcs_pkg::sweep_target(sw_first[10:0], sw_shift, sweep_reg_ff[3]);

   // next channel state for the request on the port
   always_comb begin
      sweep_reg_in       = sweep_reg_ff;
      duty_length_reg_in = duty_length_reg_ff;
      envelope_reg_in    = envelope_reg_ff;
      freq_low_reg_in    = freq_low_reg_ff;
      freq_high_reg_in   = freq_high_reg_ff;
      freq_loaded_in     = freq_loaded_ff;
      period_timer_in    = period_timer_ff;
      duty_position_in   = duty_position_ff;
      length_left_in     = length_left_ff;
      volume_now_in      = volume_now_ff;
      envelope_timer_in  = envelope_timer_ff;
      envelope_active_in = envelope_active_ff;
      dac_on_in          = dac_on_ff;
      channel_on_in      = channel_on_ff;
      sweep_timer_in     = sweep_timer_ff;
      sweep_active_in    = sweep_active_ff;
      shadow_freq_in     = shadow_freq_ff;
      level_out_in       = level_out_ff;
      rd_data            = 8'd0;

      if (req_accept) begin
         case (req_chan.command)
            pcs_pkg::CMD_WRITE: begin
               case (reg_sel)
                  pcs_pkg::REG_SWEEP: begin
                     sweep_reg_in = req_chan.write_data[6:0];
                  end
                  pcs_pkg::REG_DUTY_LEN: begin
                     duty_length_reg_in = req_chan.write_data;
                     length_left_in = pcs_pkg::LENGTH_FULL
                                      - {1'b0, req_chan.write_data[5:0]};
                  end
                  pcs_pkg::REG_ENVELOPE: begin
                     dac_on_in          = |req_chan.write_data[7:3];
                     envelope_reg_in    = req_chan.write_data;
                     envelope_timer_in  = {1'b0, req_chan.write_data[2:0]};
                     volume_now_in      = req_chan.write_data[7:4];
                     envelope_active_in = (req_chan.write_data[7:4] != 4'h0)
                                          && (req_chan.write_data[7:4] != 4'hF);
                  end
                  pcs_pkg::REG_FREQ_LOW: begin
                     freq_low_reg_in = req_chan.write_data;
                     freq_loaded_in  = {freq_loaded_ff[10:8], req_chan.write_data};
                  end
                  default: begin
                     freq_high_reg_in = req_chan.write_data;
                     freq_loaded_in   = trig_freq;
                     // length enable
                     if (req_chan.write_data[6]) begin
                        if (length_left_ff == 7'd0) begin
                           length_left_in = pcs_pkg::LENGTH_FULL;
                        end
                        channel_on_in = 1'b1;
                     end
                     // trigger
                     if (req_chan.write_data[7]) begin
                        channel_on_in = 1'b1;
                        if (length_left_in == 7'd0) begin
                           length_left_in = pcs_pkg::LENGTH_FULL;
                        end
                        period_timer_in    = pcs_pkg::timer_reload(trig_freq);
                        envelope_active_in = 1'b1;
                        envelope_timer_in  = {1'b0, env_period};
                        volume_now_in      = envelope_reg_ff[7:4];
                        shadow_freq_in     = trig_freq;
                        sweep_timer_in     = (sw_period == 3'd0) ? 4'd8 : {1'b0, sw_period};
                        sweep_active_in    = 1'b1;
                        if ((sw_shift != 3'd0) && trig_check[11]) begin
                           channel_on_in = 1'b0;
                        end
                     end
                  end
               endcase
            end
            pcs_pkg::CMD_READ: begin
               case (reg_sel)
                  pcs_pkg::REG_SWEEP:    rd_data = {1'b0, sweep_reg_ff};
                  pcs_pkg::REG_DUTY_LEN: rd_data = duty_length_reg_ff;
                  pcs_pkg::REG_ENVELOPE: rd_data = envelope_reg_ff;
                  pcs_pkg::REG_FREQ_LOW: rd_data = freq_low_reg_ff;
                  default:               rd_data = freq_high_reg_ff
                                                   & pcs_pkg::FREQ_HIGH_READ_MASK;
               endcase
            end
            pcs_pkg::CMD_PERIOD: begin
               if (period_timer_ff <= 14'd1) begin
                  period_timer_in  = pcs_pkg::timer_reload(freq_loaded_ff);
                  duty_position_in = duty_position_ff + 3'd1;
               end else begin
                  period_timer_in = period_timer_ff - 14'd1;
               end
               // level latched from the new duty step
               if (channel_on_ff && dac_on_ff
                   && pcs_pkg::DUTY_WAVE[duty_length_reg_ff[7:6]][duty_position_in]) begin
                  level_out_in = volume_now_ff;
               end else begin
                  level_out_in = 4'd0;
               end
            end
            pcs_pkg::CMD_LENGTH: begin
               if ((length_left_ff != 7'd0) && freq_high_reg_ff[6]) begin
                  length_left_in = length_left_ff - 7'd1;
                  if (length_left_ff == 7'd1) begin
                     channel_on_in = 1'b0;
                  end
               end
            end
            pcs_pkg::CMD_ENVELOPE: begin
               if (envelope_timer_ff <= 4'd1) begin
                  envelope_timer_in = (env_period == 3'd0) ? 4'd8 : {1'b0, env_period};
                  if (envelope_active_ff && (env_period != 3'd0)) begin
                     if (envelope_reg_ff[3] && (volume_now_ff != 4'hF)) begin
                        volume_now_in = volume_now_ff + 4'd1;
                     end else if (!envelope_reg_ff[3] && (volume_now_ff != 4'h0)) begin
                        volume_now_in = volume_now_ff - 4'd1;
                     end
                  end
                  if ((volume_now_in == 4'h0) || (volume_now_in == 4'hF)) begin
                     envelope_active_in = 1'b0;
                  end
               end else begin
                  envelope_timer_in = envelope_timer_ff - 4'd1;
               end
            end
            pcs_pkg::CMD_SWEEP: begin
               if (sweep_timer_ff <= 4'd1) begin
                  sweep_timer_in = (sw_period == 3'd0) ? 4'd8 : {1'b0, sw_period};
                  if (sweep_active_ff && (sw_period != 3'd0)) begin
                     if (sw_first[11]) begin
                        channel_on_in = 1'b0;
                     end else if (sw_shift != 3'd0) begin
                        // take the new frequency, then check the one after it
                        shadow_freq_in = sw_first[10:0];
                        freq_loaded_in = sw_first[10:0];
                        if (sw_second[11]) begin
                           channel_on_in = 1'b0;
                        end
                     end
                  end
               end else begin
                  sweep_timer_in = sweep_timer_ff - 4'd1;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_next.read_data = rd_data;
      rsp_next.level     = level_out_in;
      rsp_next.running   = channel_on_in && dac_on_in;
   end

   // channel state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_reg_ff       <= '0;
         duty_length_reg_ff <= '0;
         envelope_reg_ff    <= '0;
         freq_low_reg_ff    <= '0;
         freq_high_reg_ff   <= '0;
         freq_loaded_ff     <= '0;
         period_timer_ff    <= '0;
         duty_position_ff   <= '0;
         length_left_ff     <= '0;
         volume_now_ff      <= '0;
         envelope_timer_ff  <= '0;
         envelope_active_ff <= 1'b0;
         dac_on_ff          <= 1'b0;
         channel_on_ff      <= 1'b0;
         sweep_timer_ff     <= '0;
         sweep_active_ff    <= 1'b0;
         shadow_freq_ff     <= '0;
         level_out_ff       <= '0;
      end else begin
         sweep_reg_ff       <= sweep_reg_in;
         duty_length_reg_ff <= duty_length_reg_in;
         envelope_reg_ff    <= envelope_reg_in;
         freq_low_reg_ff    <= freq_low_reg_in;
         freq_high_reg_ff   <= freq_high_reg_in;
         freq_loaded_ff     <= freq_loaded_in;
         period_timer_ff    <= period_timer_in;
         duty_position_ff   <= duty_position_in;
         length_left_ff     <= length_left_in;
         volume_now_ff      <= volume_now_in;
         envelope_timer_ff  <= envelope_timer_in;
         envelope_active_ff <= envelope_active_in;
         dac_on_ff          <= dac_on_in;
         channel_on_ff      <= channel_on_in;
         sweep_timer_ff     <= sweep_timer_in;
         sweep_active_ff    <= sweep_active_in;
         shadow_freq_ff     <= shadow_freq_in;
         level_out_ff       <= level_out_in;
      end
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = req_accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rsp_take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (req_accept && !rsp_take) begin
         count_in = count_ff + 2'd1;
      end else if (!req_accept && rsp_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (req_accept) begin
         queue_ff[wr_ptr_ff] <= rsp_next;
      end
   end

   // result port
   assign rsp_chan.valid     = (count_ff != 2'd0);
   assign rsp_chan.read_data = queue_ff[rd_ptr_ff].read_data;
   assign rsp_chan.level     = queue_ff[rd_ptr_ff].level;
   assign rsp_chan.running   = queue_ff[rd_ptr_ff].running;

   // checks
   `PCS_ASSERT_NEXT(a_fill_up, req_accept && !rsp_take, count_ff == $past(count_ff) + 2'd1)
   `PCS_ASSERT_NOW(a_length_range, 1'b1, length_left_ff <= pcs_pkg::LENGTH_FULL)
   `PCS_ASSERT_NEXT(a_trigger_arms,
      req_accept && (req_chan.command == pcs_pkg::CMD_WRITE)
      && (reg_sel == pcs_pkg::REG_FREQ_HIGH) && req_chan.write_data[7],
      sweep_active_ff && envelope_active_ff && (length_left_ff != 7'd0))
   `PCS_ASSERT_NEXT(a_silent_dac,
      req_accept && (req_chan.command == pcs_pkg::CMD_PERIOD) && !dac_on_ff,
      level_out_ff == 4'd0)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for pulse_channel_with_sweep_top: directed and random requests, every result
// checked against a scoreboard that keeps its own copy of the channel state
// depends on pcs_pkg, pcs_req_if, pcs_rsp_if and the block itself

module tb_top;

   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int RANDOM_REQUESTS = 1450;
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_CYCLES     = 64;
   localparam int HOLD_AFTER      = 400;
   localparam int PRINT_LIMIT     = 30;

   // channel predictor and store of expected results
   class pulse_scoreboard;
      bit [6:0]  sweep_r;
      bit [7:0]  duty_len_r, env_r, flo_r, fhi_r;
      bit [10:0] freq_ld, shadow;
      bit [13:0] ptimer;
      bit [2:0]  duty_pos;
      bit [6:0]  len_left;
      bit [3:0]  vol, env_tmr, swp_tmr, level_q;
      bit        env_act, dac_on, chan_on, swp_act;
      pcs_pkg::rsp_type expected_rsp[$];
      int        errors, compared, triggers, overflows;

      // period timer reload from the loaded frequency
      function bit [13:0] period_reload();
         return 14'd8192 - {1'b0, freq_ld, 2'b00};
      endfunction

      // one sweep calculation, a result past 2047 silences the channel
      function bit [11:0] next_sweep_freq();
         bit [11:0] step;
         bit [11:0] nf;
         step = {1'b0, shadow >> sweep_r[2:0]};
         nf = sweep_r[3] ? ({1'b0, shadow} - step) : ({1'b0, shadow} + step);
         if (nf > 12'd2047) begin
            chan_on = 1'b0;
            overflows++;
         end
         return nf;
      endfunction

      // apply one accepted request and queue the result it causes
      function void note_request(bit [2:0] cmd, bit [3:0] idx, bit [7:0] data);
         bit [2:0]  reg_no;
         bit [2:0]  st;
         bit [2:0]  per;
         bit [11:0] nf;
         bit        wave;
         pcs_pkg::rsp_type exp_rsp;
         reg_no = 3'(idx % 5);
         exp_rsp.read_data = '0;
         case (cmd)
            pcs_pkg::CMD_WRITE: begin
               case (reg_no)
                  pcs_pkg::REG_SWEEP: sweep_r = data[6:0];
                  pcs_pkg::REG_DUTY_LEN: begin
                     duty_len_r = data;
                     len_left = pcs_pkg::LENGTH_FULL - {1'b0, data[5:0]};
                  end
                  pcs_pkg::REG_ENVELOPE: begin
                     dac_on = |data[7:3];
                     env_r = data;
                     env_tmr = {1'b0, data[2:0]};
                     vol = data[7:4];
                     env_act = (vol != 4'd0) && (vol != 4'd15);
                  end
                  pcs_pkg::REG_FREQ_LOW: begin
                     flo_r = data;
                     freq_ld[7:0] = data;
                  end
                  default: begin
                     fhi_r = data;
                     freq_ld[10:8] = data[2:0];
                     // length enable switches the channel on, refilling an empty count
                     if (data[6]) begin
                        if (len_left == 0) len_left = pcs_pkg::LENGTH_FULL;
                        chan_on = 1'b1;
                     end
                     // trigger restarts timer, envelope and sweep from the loaded values
                     if (data[7]) begin
                        triggers++;
                        chan_on = 1'b1;
                        if (len_left == 0) len_left = pcs_pkg::LENGTH_FULL;
                        ptimer = period_reload();
                        env_act = 1'b1;
                        env_tmr = {1'b0, env_r[2:0]};
                        vol = env_r[7:4];
                        shadow = freq_ld;
                        st = sweep_r[6:4];
                        swp_tmr = (st == 0) ? 4'd8 : {1'b0, st};
                        swp_act = 1'b1;
                        if (sweep_r[2:0] != 0) void'(next_sweep_freq());
                     end
                  end
               endcase
            end
            pcs_pkg::CMD_READ: begin
               case (reg_no)
                  pcs_pkg::REG_SWEEP:    exp_rsp.read_data = {1'b0, sweep_r};
                  pcs_pkg::REG_DUTY_LEN: exp_rsp.read_data = duty_len_r;
                  pcs_pkg::REG_ENVELOPE: exp_rsp.read_data = env_r;
                  pcs_pkg::REG_FREQ_LOW: exp_rsp.read_data = flo_r;
                  default: exp_rsp.read_data = fhi_r & pcs_pkg::FREQ_HIGH_READ_MASK;
               endcase
            end
            pcs_pkg::CMD_PERIOD: begin
               if (ptimer <= 1) begin
                  ptimer = period_reload();
                  duty_pos = duty_pos + 3'd1;
               end else begin
                  ptimer = ptimer - 14'd1;
               end
               // duty patterns: 12.5, 25, 50 and 75 percent
               case (duty_len_r[7:6])
                  2'd0:    wave = (duty_pos == 3'd7);
                  2'd1:    wave = (duty_pos == 3'd0) || (duty_pos == 3'd7);
                  2'd2:    wave = (duty_pos == 3'd0) || (duty_pos >= 3'd5);
                  default: wave = (duty_pos >= 3'd1) && (duty_pos <= 3'd6);
               endcase
               level_q = (chan_on && dac_on && wave) ? vol : 4'd0;
            end
            pcs_pkg::CMD_LENGTH: begin
               if (len_left > 0 && fhi_r[6]) begin
                  len_left = len_left - 7'd1;
                  if (len_left == 0) chan_on = 1'b0;
               end
            end
            pcs_pkg::CMD_ENVELOPE: begin
               per = env_r[2:0];
               if (env_tmr <= 1) begin
                  env_tmr = (per == 0) ? 4'd8 : {1'b0, per};
                  if (env_act && per > 0) begin
                     if (env_r[3] && vol < 15) vol = vol + 4'd1;
                     else if (!env_r[3] && vol > 0) vol = vol - 4'd1;
                  end
                  if (vol == 4'd0 || vol == 4'd15) env_act = 1'b0;
               end else begin
                  env_tmr = env_tmr - 4'd1;
               end
            end
            pcs_pkg::CMD_SWEEP: begin
               st = sweep_r[6:4];
               if (swp_tmr <= 1) begin
                  swp_tmr = (st == 0) ? 4'd8 : {1'b0, st};
                  if (swp_act && st > 0) begin
                     nf = next_sweep_freq();
                     if (nf <= 12'd2047 && sweep_r[2:0] != 0) begin
                        shadow = nf[10:0];
                        freq_ld = nf[10:0];
                        void'(next_sweep_freq());
                     end
                     void'(next_sweep_freq());
                  end
               end else begin
                  swp_tmr = swp_tmr - 4'd1;
               end
            end
            default: ;
         endcase
         exp_rsp.level = level_q;
         exp_rsp.running = chan_on & dac_on;
         expected_rsp.push_back(exp_rsp);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
      endtask

      // compare one result with the oldest expectation
      task check_response(logic [7:0] rd, logic [3:0] lvl, logic run);
         pcs_pkg::rsp_type want;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("result rd=%h level=%h running=%b with nothing outstanding",
                                      rd, lvl, run));
            return;
         end
         want = expected_rsp.pop_front();
         compared++;
         if (rd !== want.read_data)
            report_mismatch($sformatf("result %0d read_data %h, want %h",
                                      compared, rd, want.read_data));
         if (lvl !== want.level)
            report_mismatch($sformatf("result %0d level %h, want %h", compared, lvl, want.level));
         if (run !== want.running)
            report_mismatch($sformatf("result %0d running %b, want %b",
                                      compared, run, want.running));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   sender_steady;
   bit   rsp_holding;
   int   sent_count;
   int   directed_count;
   int   idle_cycles;

   pulse_scoreboard channel_sb = new();

   pcs_req_if req_if ();
   pcs_rsp_if rsp_if ();

   pulse_channel_with_sweep_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #10 clock = ~clock;

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // k-th index that folds onto register r
   function automatic logic [3:0] reg_alias(logic [2:0] r, int k);
      return 4'(r + 5 * k);
   endfunction

   function automatic logic [3:0] random_alias(logic [2:0] r);
      return reg_alias(r, $urandom_range(0, (15 - r) / 5));
   endfunction

   task automatic sender_pause();
      int gap;
      gap = (sender_steady || rsp_holding) ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // offer one request and hold it until taken
   task automatic send_request(input logic [2:0] cmd, input logic [3:0] idx,
                               input logic [7:0] data);
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.reg_index  <= idx;
      req_if.write_data <= data;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      channel_sb.note_request(cmd, idx, data);
      sent_count++;
      sender_pause();
   endtask

   // well-formed note: register setup, trigger, then a run of ticks, reads and writes
   task automatic play_note();
      int         roll;
      logic [7:0] fhi;
      sender_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0)
         send_request(pcs_pkg::CMD_WRITE, random_alias(pcs_pkg::REG_SWEEP),
                      8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0)
         send_request(pcs_pkg::CMD_WRITE, random_alias(pcs_pkg::REG_DUTY_LEN),
                      8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0)
         send_request(pcs_pkg::CMD_WRITE, random_alias(pcs_pkg::REG_ENVELOPE),
                      8'($urandom_range(0, 255)));
      // high frequencies keep the period short so the duty position moves
      send_request(pcs_pkg::CMD_WRITE, random_alias(pcs_pkg::REG_FREQ_LOW),
                   $urandom_range(0, 1) ? 8'($urandom_range(240, 255))
                                        : 8'($urandom_range(0, 255)));
      fhi = {1'b1, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
             $urandom_range(0, 1) ? 3'd7 : 3'($urandom_range(0, 7))};
      send_request(pcs_pkg::CMD_WRITE, random_alias(pcs_pkg::REG_FREQ_HIGH), fhi);
      repeat ($urandom_range(15, 60)) begin
         roll = $urandom_range(0, 99);
         if (roll < 50)
            send_request(pcs_pkg::CMD_PERIOD, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
         else if (roll < 62)
            send_request(pcs_pkg::CMD_LENGTH, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
         else if (roll < 74)
            send_request(pcs_pkg::CMD_ENVELOPE, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
         else if (roll < 86)
            send_request(pcs_pkg::CMD_SWEEP, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
         else if (roll < 96)
            send_request(pcs_pkg::CMD_READ, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
         else
            send_request(pcs_pkg::CMD_WRITE, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
      end
   endtask

   // result side: random stalls, steady stretches and one long hold-off
   initial begin : result_sink
      int stall_left;
      int steady_left;
      bit hold_done;
      stall_left = 0;
      steady_left = 0;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && channel_sb.compared >= HOLD_AFTER) begin
            // output queue fills and the request side backs up
            hold_done = 1'b1;
            rsp_holding = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_holding = 1'b0;
         end else if (steady_left > 0) begin
            steady_left--;
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
            if ($urandom_range(0, 99) == 0) steady_left = $urandom_range(50, 150);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         channel_sb.check_response(rsp_if.read_data, rsp_if.level, rsp_if.running);
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
         $display("pulse_channel_with_sweep_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int roll;
      req_if.valid = 1'b0;
      req_if.command = pcs_pkg::CMD_READ;
      req_if.reg_index = 4'd0;
      req_if.write_data = 8'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset state: a read, then every tick with all timers at zero
      send_request(pcs_pkg::CMD_READ, reg_alias(pcs_pkg::REG_SWEEP, 0), 8'h00);
      send_request(pcs_pkg::CMD_PERIOD, 4'hF, 8'hFF);
      send_request(pcs_pkg::CMD_ENVELOPE, 4'h0, 8'h00);
      send_request(pcs_pkg::CMD_SWEEP, 4'h0, 8'h00);
      send_request(pcs_pkg::CMD_LENGTH, 4'h0, 8'h00);
      // loud rising envelope, widest duty, full length
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_ENVELOPE, 0), 8'hFF);
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_DUTY_LEN, 0), 8'hC0);
      // adding sweep from the top frequency overflows at the trigger
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_SWEEP, 0), 8'h11);
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_FREQ_LOW, 0), 8'hFF);
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_FREQ_HIGH, 0), 8'hC7);
      send_request(pcs_pkg::CMD_READ, reg_alias(pcs_pkg::REG_FREQ_HIGH, 0), 8'h00);
      // subtracting sweep through a folded index, retrigger from a low frequency
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_SWEEP, 3), 8'h19);
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_FREQ_HIGH, 1), 8'h80);
      send_request(pcs_pkg::CMD_SWEEP, 4'h0, 8'h00);
      send_request(pcs_pkg::CMD_PERIOD, 4'h0, 8'h00);
      // unused commands change nothing
      send_request(CMD_SPARE_LO, 4'hE, 8'h5A);
      send_request(CMD_SPARE_HI, 4'h7, 8'hA5);
      // length of one with length enable: the next length tick silences the channel
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_DUTY_LEN, 1), 8'h3F);
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_FREQ_HIGH, 0), 8'h40);
      send_request(pcs_pkg::CMD_LENGTH, 4'h0, 8'h00);
      // read back through folded indexes
      send_request(pcs_pkg::CMD_READ, reg_alias(pcs_pkg::REG_SWEEP, 2), 8'h00);
      send_request(pcs_pkg::CMD_READ, reg_alias(pcs_pkg::REG_DUTY_LEN, 2), 8'h00);
      send_request(pcs_pkg::CMD_READ, reg_alias(pcs_pkg::REG_ENVELOPE, 2), 8'h00);
      send_request(pcs_pkg::CMD_READ, reg_alias(pcs_pkg::REG_FREQ_LOW, 2), 8'h00);
      // envelope of zero turns the dac off
      send_request(pcs_pkg::CMD_WRITE, reg_alias(pcs_pkg::REG_ENVELOPE, 0), 8'h00);
      send_request(pcs_pkg::CMD_PERIOD, 4'h0, 8'h00);
      directed_count = sent_count;

      // random part: mostly notes, some noise and some half-built notes
      while (sent_count < directed_count + RANDOM_REQUESTS) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            play_note();
         end else if (roll < 90) begin
            sender_steady = 1'b0;
            repeat ($urandom_range(3, 12))
               send_request(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                            8'($urandom_range(0, 255)));
         end else begin
            // frequency high written on its own, then frame ticks
            sender_steady = 1'b0;
            send_request(pcs_pkg::CMD_WRITE, random_alias(pcs_pkg::REG_FREQ_HIGH),
                         8'($urandom_range(0, 255)));
            repeat ($urandom_range(2, 8))
               send_request(3'($urandom_range(pcs_pkg::CMD_LENGTH, pcs_pkg::CMD_SWEEP)),
                            4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         end
      end
      @(negedge clock);
      req_if.valid <= 1'b0;

      // drain, then idle before the summary
      while (channel_sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run: %0d requests (%0d directed), %0d results compared, %0d mismatches",
               sent_count, directed_count, channel_sb.compared, channel_sb.errors);
      $display("run: %0d triggers, %0d sweep overflow checks tripped, one long result stall",
               channel_sb.triggers, channel_sb.overflows);
      if (channel_sb.errors == 0)
         $display("pulse_channel_with_sweep_top verification clean");
      else
         $display("pulse_channel_with_sweep_top verification failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/pcs_pkg.sv
design/pcs_req_if.sv
design/pcs_rsp_if.sv
design/pulse_channel_with_sweep_top.sv
tb/tb_top.sv
